>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the snowmelt step block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/ddsm_pkg.sv
// Types, constants and the control store of the degree-day snowmelt step.
// No dependencies; used by ddsm_sequencer and degree_day_snowmelt_step.
`timescale 1ns / 1ps

package ddsm_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam logic [16:0] COVER_ONE = 17'h10000;

    // Register indexes of the configuration port.
    typedef enum logic [2:0] {
        CFG_SNOW_CORR  = 3'd0,
        CFG_RAIN_THR   = 3'd1,
        CFG_MELT_THR   = 3'd2,
        CFG_MELT_FACT  = 3'd3,
        CFG_INIT_STORE = 3'd4
    } t_cfg_idx;

    // Condition a step waits on before it completes.
    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_WAIT_IN  = 2'd1,
        COND_WAIT_OUT = 2'd2
    } t_cond;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_SNOW  = 2'd1,
        MUL_POT   = 2'd2,
        MUL_SCALE = 2'd3
    } t_mul_sel;

    typedef struct packed {
        t_cond    cond;
        t_mul_sel mul;
        logic     ld_snow;
        logic     ld_melt;
        logic     ld_out;
        logic     jump;
        t_step    target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_seq_status;

    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_SNOW  = 3'd1;
    localparam t_step STEP_POT   = 3'd2;
    localparam t_step STEP_MELT  = 3'd3;
    localparam t_step STEP_SCALE = 3'd4;
    localparam t_step STEP_OUT   = 3'd5;

    // Microprogram: one control word per step.
    function automatic t_ctrl ucode_rom(input t_step addr);
        t_ctrl w;
        w = '{cond: COND_ALWAYS, mul: MUL_NONE, ld_snow: 1'b0, ld_melt: 1'b0,
              ld_out: 1'b0, jump: 1'b0, target: STEP_IDLE};
        case (addr)
            STEP_IDLE:  w.cond = COND_WAIT_IN;
            STEP_SNOW:  w.mul = MUL_SNOW;
            STEP_POT: begin
                w.mul     = MUL_POT;
                w.ld_snow = 1'b1;
            end
            STEP_MELT:  w.ld_melt = 1'b1;
            STEP_SCALE: w.mul = MUL_SCALE;
            STEP_OUT: begin
                w.cond   = COND_WAIT_OUT;
                w.ld_out = 1'b1;
                w.jump   = 1'b1;
                w.target = STEP_IDLE;
            end
            default: begin
                w.jump   = 1'b1;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/ddsm_sequencer.sv
// Step counter and control store of the snowmelt step block.
// Depends on ddsm_pkg for the control word and microprogram.
`timescale 1ns / 1ps

module ddsm_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ddsm_pkg::t_seq_status i_status,
    output ddsm_pkg::t_ctrl      o_ctrl,
    output logic                 o_go
);

    ddsm_pkg::t_step r_step;
    ddsm_pkg::t_step n_step;
    ddsm_pkg::t_ctrl ctrl;

    assign ctrl   = ddsm_pkg::ucode_rom(r_step);
    assign o_ctrl = ctrl;

    always_comb begin
        case (ctrl.cond)
            ddsm_pkg::COND_ALWAYS:   o_go = 1'b1;
            ddsm_pkg::COND_WAIT_IN:  o_go = i_status.in_valid;
            ddsm_pkg::COND_WAIT_OUT: o_go = i_status.out_free;
            default:                 o_go = 1'b1;
        endcase
    end

    // A step whose condition fails jumps to itself.
    always_comb begin
        if (!o_go) begin
            n_step = r_step;
        end else if (ctrl.jump) begin
            n_step = ctrl.target;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ddsm_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> hw/rtl/degree_day_snowmelt_step.sv
// Top level of the degree-day snowmelt step: configuration registers,
// shared multiplier datapath and output register. Depends on ddsm_pkg,
// ddsm_sequencer and assert_macros.svh.
//
// Usage. Each input item is one time step (air temperature, precipitation,
// optional cover fraction) and yields exactly one result item on the output
// channel. Both channels carry valid and stall; an item moves at a rising
// edge with valid high and stall low. Configuration is written through a
// separate valid/ready port that is always ready; index i selects register
// i, indexes beyond the list are ignored. Write it only while idle.
// An item is taken in the idle step, then a short microprogram runs
// five more steps on one shared 32x17 multiplier (snowfall, potential
// melt, cover scaling) and loads the output register in its last step;
// no new item is taken until the microprogram is back in the idle step.
// The next item is taken while a finished result still waits in the output
// register; if the receiver stalls, the final step holds until the output
// register is free, and the input then stalls too.
// Reset (synchronous, active low) returns the registers to their defaults,
// clears the store, restores full cover and rearms the first-item load.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module degree_day_snowmelt_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_air_temp,
    input  logic [23:0]        i_precip,
    input  logic               i_cover_valid,
    input  logic [16:0]        i_cover_fraction,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [23:0]        o_rain_out,
    output logic [25:0]        o_snow_out,
    output logic [31:0]        o_snow_store_out,
    output logic [31:0]        o_melt_out,
    output logic [32:0]        o_runoff_total,
    output logic [32:0]        o_runoff_scaled,
    // configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    // Configuration registers.
    logic [15:0]        r_snow_corr;
    logic signed [15:0] r_rain_thr;
    logic signed [15:0] r_melt_thr;
    logic [15:0]        r_melt_fact;
    logic [31:0]        r_init_store;

    // State kept across items.
    logic [31:0] r_store;
    logic [16:0] r_cover;
    logic        r_started;

    // Working registers of the current item.
    logic [23:0] r_precip;
    logic [15:0] r_dt;
    logic        r_is_rain;
    logic        r_melt_on;
    logic [25:0] r_snow;
    logic [31:0] r_melt;
    logic [48:0] r_prod;
    logic        r_out_valid;

    ddsm_pkg::t_ctrl       ctrl;
    ddsm_pkg::t_seq_status status;
    logic                  go;
    logic                  in_accept;
    logic                  out_fire;
    logic                  out_free;
    logic signed [16:0]    temp_diff;
    logic [31:0]           mul_a;
    logic [16:0]           mul_b;
    logic [23:0]           pot;
    logic [23:0]           rain;
    logic [33:0]           store_sum;
    logic [31:0]           store_new;

    assign out_free = !r_out_valid || !i_out_stall;
    assign status   = '{in_valid: i_in_valid, out_free: out_free};

    ddsm_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_go     (go)
    );

    assign o_in_stall  = (ctrl.cond != ddsm_pkg::COND_WAIT_IN);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_fire    = ctrl.ld_out && go;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snow_corr  <= 16'd16384;
            r_rain_thr   <= '0;
            r_melt_thr   <= '0;
            r_melt_fact  <= 16'd768;
            r_init_store <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ddsm_pkg::CFG_SNOW_CORR:  r_snow_corr  <= i_cfg_data[15:0];
                ddsm_pkg::CFG_RAIN_THR:   r_rain_thr   <= i_cfg_data[15:0];
                ddsm_pkg::CFG_MELT_THR:   r_melt_thr   <= i_cfg_data[15:0];
                ddsm_pkg::CFG_MELT_FACT:  r_melt_fact  <= i_cfg_data[15:0];
                ddsm_pkg::CFG_INIT_STORE: r_init_store <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // When melting, the difference is positive and fits in 16 bits.
    assign temp_diff = {i_air_temp[15], i_air_temp} - {r_melt_thr[15], r_melt_thr};

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_precip  <= i_precip;
            r_dt      <= temp_diff[15:0];
            r_is_rain <= (i_air_temp > r_rain_thr);
            r_melt_on <= (i_air_temp > r_melt_thr);
        end
    end

    always_comb begin
        case (ctrl.mul)
            ddsm_pkg::MUL_SNOW: begin
                mul_a = {8'd0, r_precip};
                mul_b = {1'b0, r_snow_corr};
            end
            ddsm_pkg::MUL_POT: begin
                mul_a = {16'd0, r_dt};
                mul_b = {1'b0, r_melt_fact};
            end
            ddsm_pkg::MUL_SCALE: begin
                mul_a = r_melt;
                mul_b = r_cover;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign pot = r_prod[31:8];

    always_ff @(posedge i_clk) begin
        if (ctrl.mul != ddsm_pkg::MUL_NONE) begin
            r_prod <= 49'(mul_a) * 49'(mul_b);
        end
        if (ctrl.ld_snow) begin
            r_snow <= r_is_rain ? '0 : r_prod[39:14];
        end
        if (ctrl.ld_melt) begin
            if (!r_melt_on) begin
                r_melt <= '0;
            end else if (32'(pot) < r_store) begin
                r_melt <= 32'(pot);
            end else begin
                r_melt <= r_store;
            end
        end
    end

    // Melt never exceeds the old store, so the sum cannot go negative.
    assign rain      = r_is_rain ? r_precip : '0;
    assign store_sum = 34'(r_store) + 34'(r_snow) - 34'(r_melt);
    assign store_new = (|store_sum[33:32]) ? '1 : store_sum[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store   <= '0;
            r_cover   <= ddsm_pkg::COVER_ONE;
            r_started <= 1'b0;
        end else begin
            if (in_accept) begin
                if (!r_started) begin
                    r_store   <= r_init_store;
                    r_started <= 1'b1;
                end
                if (i_cover_valid) begin
                    r_cover <= (i_cover_fraction > ddsm_pkg::COVER_ONE) ?
                               ddsm_pkg::COVER_ONE : i_cover_fraction;
                end
            end else if (out_fire) begin
                r_store <= store_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            o_rain_out       <= rain;
            o_snow_out       <= r_snow;
            o_snow_store_out <= store_new;
            o_melt_out       <= r_melt;
            o_runoff_total   <= 33'(r_melt) + 33'(rain);
            o_runoff_scaled  <= 33'(r_prod[47:16]) + 33'(rain);
        end
    end

    `ASSERT_ALWAYS(a_no_load_when_held, i_clk, i_rst_n, !(out_fire && r_out_valid && i_out_stall))
    `ASSERT_NEXT(a_started_after_item, i_clk, i_rst_n, in_accept, r_started)
    `ASSERT_NEXT(a_melt_capped, i_clk, i_rst_n, ctrl.ld_melt, r_melt <= r_store)
    `ASSERT_ALWAYS(a_cover_in_range, i_clk, i_rst_n, r_cover <= ddsm_pkg::COVER_ONE)

endmodule

>>> tb/degree_day_snowmelt_step_tb.sv
// Self-checking testbench for degree_day_snowmelt_step: directed and random time steps,
// random idling on both channels, and register changes between phases.
// Depends on ddsm_pkg and the degree_day_snowmelt_step RTL.
`timescale 1ns / 1ps

module degree_day_snowmelt_step_tb;

    localparam int          HALF_PERIOD  = 4;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          PHASE_ITEMS  = 200;
    localparam int          DRAIN_ITEMS  = 400;
    localparam int          MIXED_PHASES = 6;
    localparam logic [2:0]  CFG_UNUSED_IDX = 3'd7;
    localparam longint      STORE_MAX    = 64'h0000_0000_FFFF_FFFF;

    typedef struct {
        logic signed [15:0] air_temp;
        logic [23:0]        precip;
        logic               cover_valid;
        logic [16:0]        cover_fraction;
    } t_step_in;

    typedef struct {
        logic [23:0] rain;
        logic [25:0] snow;
        logic [31:0] store;
        logic [31:0] melt;
        logic [32:0] runoff_total;
        logic [32:0] runoff_scaled;
    } t_step_out;

    // Tracks the snowpack alongside the block and holds the results still owed by it.
    class t_snowpack_scoreboard;
        logic [15:0]        snow_corr;
        logic signed [15:0] rain_thr;
        logic signed [15:0] melt_thr;
        logic [15:0]        melt_fact;
        logic [31:0]        init_store;
        logic [31:0]        swe;
        logic [16:0]        cover_held;
        bit                 started;
        t_step_out          owed[$];
        int errors, checked, n_rain, n_snow, n_capped, n_empty, n_saturated, n_clipped;

        function new();
            snow_corr  = 16'd16384;
            rain_thr   = 16'sd0;
            melt_thr   = 16'sd0;
            melt_fact  = 16'd768;
            init_store = 32'd0;
            swe        = 32'd0;
            cover_held = ddsm_pkg::COVER_ONE;
            started    = 1'b0;
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] data);
            case (idx)
                ddsm_pkg::CFG_SNOW_CORR:  snow_corr  = data[15:0];
                ddsm_pkg::CFG_RAIN_THR:   rain_thr   = data[15:0];
                ddsm_pkg::CFG_MELT_THR:   melt_thr   = data[15:0];
                ddsm_pkg::CFG_MELT_FACT:  melt_fact  = data[15:0];
                ddsm_pkg::CFG_INIT_STORE: init_store = data;
                default: ;
            endcase
        endfunction

        function void take_step(t_step_in s);
            longint    rain, snow, melt, pot, dt, nxt;
            t_step_out e;
            if (!started) begin
                swe     = init_store;
                started = 1'b1;
            end
            if (s.cover_valid) begin
                if (s.cover_fraction > ddsm_pkg::COVER_ONE) n_clipped++;
                cover_held = (s.cover_fraction > ddsm_pkg::COVER_ONE) ?
                             ddsm_pkg::COVER_ONE : s.cover_fraction;
            end
            rain = 0;
            snow = 0;
            melt = 0;
            if (s.air_temp > rain_thr) begin
                rain = longint'(s.precip);
                n_rain++;
            end else begin
                snow = (longint'(s.precip) * longint'(snow_corr)) >> 14;
                n_snow++;
            end
            if (s.air_temp > melt_thr) begin
                dt   = longint'(s.air_temp) - longint'(melt_thr);
                pot  = (dt * longint'(melt_fact)) >> 8;
                melt = (pot < longint'(swe)) ? pot : longint'(swe);
                if (swe == 32'd0 && pot > 0) n_empty++;
                else if (pot > longint'(swe)) n_capped++;
            end
            nxt = longint'(swe) + snow - melt;
            if (nxt > STORE_MAX) begin
                nxt = STORE_MAX;
                n_saturated++;
            end
            swe = 32'(nxt);
            e.rain          = 24'(rain);
            e.snow          = 26'(snow);
            e.store         = swe;
            e.melt          = 32'(melt);
            e.runoff_total  = 33'(melt + rain);
            e.runoff_scaled = 33'(((melt * longint'(cover_held)) >> 16) + rain);
            owed.push_back(e);
        endfunction

        function void compare_field(string field, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_step(t_step_out r);
            t_step_out e;
            if (owed.size() == 0) begin
                $display("%0t: result item arrived with no time step outstanding", $time);
                errors++;
                return;
            end
            e = owed.pop_front();
            checked++;
            compare_field("rain_out", longint'(e.rain), longint'(r.rain));
            compare_field("snow_out", longint'(e.snow), longint'(r.snow));
            compare_field("snow_store_out", longint'(e.store), longint'(r.store));
            compare_field("melt_out", longint'(e.melt), longint'(r.melt));
            compare_field("runoff_total", longint'(e.runoff_total), longint'(r.runoff_total));
            compare_field("runoff_scaled", longint'(e.runoff_scaled),
                          longint'(r.runoff_scaled));
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_air_temp;
    logic [23:0]        i_precip;
    logic               i_cover_valid;
    logic [16:0]        i_cover_fraction;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [23:0]        o_rain_out;
    logic [25:0]        o_snow_out;
    logic [31:0]        o_snow_store_out;
    logic [31:0]        o_melt_out;
    logic [32:0]        o_runoff_total;
    logic [32:0]        o_runoff_scaled;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    t_snowpack_scoreboard snowpack;
    bit                 quiet = 1'b0;
    bit                 gaps_on = 1'b1;
    int                 cycle_count = 0;
    int                 reg_writes = 0;

    degree_day_snowmelt_step dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_air_temp       (i_air_temp),
        .i_precip         (i_precip),
        .i_cover_valid    (i_cover_valid),
        .i_cover_fraction (i_cover_fraction),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_rain_out       (o_rain_out),
        .o_snow_out       (o_snow_out),
        .o_snow_store_out (o_snow_store_out),
        .o_melt_out       (o_melt_out),
        .o_runoff_total   (o_runoff_total),
        .o_runoff_scaled  (o_runoff_scaled),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: stall bursts, short free runs and the odd long free stretch.
    initial begin
        int pick;
        int run;
        bit hold;
        i_out_stall = 1'b0;
        forever begin
            pick = $urandom_range(0, 7);
            run  = (pick == 0) ? $urandom_range(60, 120) : $urandom_range(1, 17);
            hold = (pick == 1 || pick == 2);
            repeat (run) begin
                @(negedge i_clk);
                i_out_stall <= hold && !quiet;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_step_out seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.rain          = o_rain_out;
            seen.snow          = o_snow_out;
            seen.store         = o_snow_store_out;
            seen.melt          = o_melt_out;
            seen.runoff_total  = o_runoff_total;
            seen.runoff_scaled = o_runoff_scaled;
            snowpack.check_step(seen);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        snowpack.set_register(idx, data);
        reg_writes++;
    endtask

    // The upper halves of the 16-bit registers' data carry noise that must be ignored.
    task automatic configure(input logic [15:0] corr, input logic [15:0] rain_thr,
                             input logic [15:0] melt_thr, input logic [15:0] fact,
                             input logic [31:0] init);
        write_reg(ddsm_pkg::CFG_SNOW_CORR, {16'($urandom), corr});
        write_reg(ddsm_pkg::CFG_RAIN_THR, {16'($urandom), rain_thr});
        write_reg(ddsm_pkg::CFG_MELT_THR, {16'($urandom), melt_thr});
        write_reg(ddsm_pkg::CFG_MELT_FACT, {16'($urandom), fact});
        write_reg(ddsm_pkg::CFG_INIT_STORE, init);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'(int'($urandom_range(0, 5120)) - 2560);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [15:0] corr, fact;
        case ($urandom_range(0, 3))
            0:       corr = 16'd0;
            1:       corr = 16'hFFFF;
            2:       corr = 16'd16384;
            default: corr = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0:       fact = 16'd0;
            1:       fact = 16'hFFFF;
            2:       fact = 16'($urandom_range(0, 2048));
            default: fact = 16'($urandom);
        endcase
        configure(corr, pick_threshold(), pick_threshold(), fact, $urandom);
    endtask

    function automatic t_step_in make_step(input int temp, input logic [23:0] precip,
                                           input logic cv, input logic [16:0] cf);
        t_step_in s;
        if (temp > 32767) temp = 32767;
        if (temp < -32768) temp = -32768;
        s.air_temp       = 16'(temp);
        s.precip         = precip;
        s.cover_valid    = cv;
        s.cover_fraction = cf;
        return s;
    endfunction

    // Temperatures cluster around the thresholds; a drain step is warm enough to melt hard.
    function automatic t_step_in random_step(input bit drain);
        int          temp;
        logic [23:0] precip;
        logic [16:0] cf;
        case ($urandom_range(0, 3))
            0: temp = int'($urandom_range(0, 65535)) - 32768;
            1: temp = int'(snowpack.rain_thr) + int'($urandom_range(0, 6)) - 3;
            2: temp = int'(snowpack.melt_thr) + int'($urandom_range(0, 1200)) - 600;
            default: temp = int'($urandom_range(0, 5120)) - 2560;
        endcase
        if (drain) temp = $urandom_range(16'h4000, 16'h7FFF);
        case ($urandom_range(0, 7))
            0:       precip = 24'd0;
            1:       precip = 24'hFFFFFF;
            2, 3, 4: precip = 24'($urandom_range(0, 1023));
            default: precip = 24'($urandom);
        endcase
        case ($urandom_range(0, 15))
            0, 1:    cf = 17'($urandom_range(65537, 131071));
            2, 3:    cf = ddsm_pkg::COVER_ONE;
            4:       cf = 17'd0;
            default: cf = 17'($urandom_range(0, 65535));
        endcase
        return make_step(temp, precip, 1'($urandom_range(0, 1)), cf);
    endfunction

    task automatic send_step(input t_step_in s);
        int gap;
        if (!quiet && gaps_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 17);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid       <= 1'b1;
        i_air_temp       <= s.air_temp;
        i_precip         <= s.precip;
        i_cover_valid    <= s.cover_valid;
        i_cover_fraction <= s.cover_fraction;
        do @(posedge i_clk); while (o_in_stall);
        snowpack.take_step(s);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (snowpack.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items, input bit drain);
        for (int k = 0; k < n_items; k++) begin
            if (k % 50 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            send_step(random_step(drain));
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_air_temp       = '0;
        i_precip         = '0;
        i_cover_valid    = 1'b0;
        i_cover_fraction = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        snowpack         = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Full initial store, so the very first snowfall has to saturate.
        write_reg(CFG_UNUSED_IDX, 32'h1234_5678);
        configure(16'hFFFF, 16'h0000, 16'h0000, 16'd768, 32'hFFFF_FFFF);
        send_step(make_step(-32768, 24'hFFFFFF, 1'b0, 17'h00000));
        send_step(make_step(0, 24'h000100, 1'b1, 17'h10000));
        send_step(make_step(1, 24'h000100, 1'b1, 17'h00000));
        send_step(make_step(32767, 24'hFFFFFF, 1'b0, 17'h1FFFF));
        send_step(make_step(32767, 24'h000000, 1'b1, 17'h1FFFF));
        send_step(make_step(256, 24'h000001, 1'b1, 17'h10001));
        send_step(make_step(256, 24'h123456, 1'b1, 17'h08000));
        send_step(make_step(-1, 24'h000000, 1'b0, 17'h00000));
        send_step(make_step(-256, 24'h000001, 1'b1, 17'h00001));
        wait_drained();

        // Lowest thresholds: only the coldest temperature is snow, and it is zeroed.
        configure(16'h0000, 16'h8000, 16'h8000, 16'hFFFF, 32'h0000_0000);
        send_step(make_step(-32768, 24'hFFFFFF, 1'b1, 17'h0FFFF));
        send_step(make_step(32767, 24'hFFFFFF, 1'b1, 17'h0FFFF));
        send_step(make_step(-32767, 24'h800000, 1'b0, 17'h00000));
        send_step(make_step(16'sh5A5A, 24'h5A5A5A, 1'b1, 17'h0A5A5));
        wait_drained();

        // Highest thresholds: nothing can be rain and nothing can melt.
        configure(16'd16384, 16'h7FFF, 16'h7FFF, 16'h0000, 32'h0000_0100);
        send_step(make_step(32767, 24'hFFFFFF, 1'b0, 17'h00000));
        send_step(make_step(-32768, 24'hAAAAAA, 1'b1, 17'h15555));
        send_step(make_step(16'sh7FFE, 24'h555555, 1'b1, 17'h0AAAA));
        wait_drained();

        // Melt the once-saturated store down to nothing, then carry on with mixed settings.
        configure(16'd16384, 16'h8000, 16'h8000, 16'hFFFF, $urandom);
        run_phase(DRAIN_ITEMS, 1'b1);
        for (int p = 0; p < MIXED_PHASES; p++) begin
            if (p == MIXED_PHASES - 1) quiet = 1'b1;
            random_config();
            run_phase(PHASE_ITEMS, 1'b0);
        end

        $display("Checked %0d time steps: %0d rain, %0d snow, %0d with melt capped by the store,",
                 snowpack.checked, snowpack.n_rain, snowpack.n_snow, snowpack.n_capped);
        $display("%0d on an empty store, %0d store saturations, %0d clipped covers, %0d writes.",
                 snowpack.n_empty, snowpack.n_saturated, snowpack.n_clipped, reg_writes);
        if (snowpack.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ddsm_pkg.sv
hw/rtl/ddsm_sequencer.sv
hw/rtl/degree_day_snowmelt_step.sv
tb/degree_day_snowmelt_step_tb.sv
